### hdl/lcd_seq_pkg.sv
package lcd_seq_pkg;

   // Widths of the transfer fields and of the step counter
   localparam int WaitWidth = 16;
   localparam int StepBits  = 4;

   // Step indexes of the last transfer of a run
   localparam logic [StepBits-1:0] ByteLastStep = 4'd1;
   localparam logic [StepBits-1:0] InitLastStep = 4'd12;
   localparam int InitSteps = 13;

   // Built-in waits of the power-on sequence, in microseconds
   localparam logic [WaitWidth:0] BootWait   = 17'd15000;
   localparam logic [WaitWidth:0] Reset1Wait = 17'd5000;
   localparam logic [WaitWidth:0] Reset2Wait = 17'd1000;

   // Address bases and fixed bytes of the display commands
   localparam logic [7:0] CursorBase = 8'h80;
   localparam logic [7:0] GlyphBase  = 8'h40;
   localparam logic [7:0] ClearByte  = 8'h01;
   localparam logic [7:0] HomeByte   = 8'h02;

   typedef enum logic [2:0] {
      CMD_INIT   = 3'd0,
      CMD_BYTE   = 3'd1,
      CMD_DATA   = 3'd2,
      CMD_CURSOR = 3'd3,
      CMD_CLEAR  = 3'd4,
      CMD_HOME   = 3'd5,
      CMD_GLYPH  = 3'd6
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_ROW1_BASE    = 3'd0,
      CSR_ROW2_BASE    = 3'd1,
      CSR_ROW3_BASE    = 3'd2,
      CSR_ROW4_BASE    = 3'd3,
      CSR_COMMAND_WAIT = 3'd4,
      CSR_DATA_WAIT    = 3'd5,
      CSR_LONG_WAIT    = 3'd6,
      CSR_ENABLE_PULSE = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      RUN_NONE = 2'd0,
      RUN_BYTE = 2'd1,
      RUN_INIT = 2'd2
   } run_kind_type;

   // Wait that follows the low nibble of a byte
   typedef enum logic [1:0] {
      WCLS_CMD  = 2'd0,
      WCLS_DATA = 2'd1,
      WCLS_LONG = 2'd2
   } wait_class_type;

   typedef enum logic [2:0] {
      WSEL_ZERO   = 3'd0,
      WSEL_BOOT   = 3'd1,
      WSEL_RESET1 = 3'd2,
      WSEL_RESET2 = 3'd3,
      WSEL_CMD    = 3'd4,
      WSEL_FINAL  = 3'd5
   } wait_sel_type;

   typedef struct packed {
      logic [3:0]   nibble;
      logic         strobe;
      wait_sel_type wsel;
   } step_entry_type;

   // Controller to datapath
   typedef struct packed {
      logic                capture;
      logic                load;
      logic [StepBits-1:0] step;
      logic                last;
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      run_kind_type kind;
   } dp_status_type;

   // Power-on sequence, one entry per transfer
   function automatic step_entry_type init_entry(input logic [StepBits-1:0] step);
      step_entry_type e;
      e = '{nibble: 4'h0, strobe: 1'b1, wsel: WSEL_ZERO};
      case (step)
         4'd0:    e = '{nibble: 4'h0, strobe: 1'b0, wsel: WSEL_BOOT};
         4'd1:    e = '{nibble: 4'h3, strobe: 1'b1, wsel: WSEL_RESET1};
         4'd2:    e = '{nibble: 4'h3, strobe: 1'b1, wsel: WSEL_RESET2};
         4'd3:    e = '{nibble: 4'h3, strobe: 1'b1, wsel: WSEL_RESET2};
         4'd4:    e = '{nibble: 4'h2, strobe: 1'b1, wsel: WSEL_RESET1};
         4'd5:    e = '{nibble: 4'h2, strobe: 1'b1, wsel: WSEL_ZERO};
         4'd6:    e = '{nibble: 4'h8, strobe: 1'b1, wsel: WSEL_CMD};
         4'd7:    e = '{nibble: 4'h0, strobe: 1'b1, wsel: WSEL_ZERO};
         4'd8:    e = '{nibble: 4'hC, strobe: 1'b1, wsel: WSEL_CMD};
         4'd9:    e = '{nibble: 4'h0, strobe: 1'b1, wsel: WSEL_ZERO};
         4'd10:   e = '{nibble: 4'h6, strobe: 1'b1, wsel: WSEL_CMD};
         4'd11:   e = '{nibble: 4'h0, strobe: 1'b1, wsel: WSEL_ZERO};
         4'd12:   e = '{nibble: 4'h1, strobe: 1'b1, wsel: WSEL_FINAL};
         default: e = '{nibble: 4'h0, strobe: 1'b1, wsel: WSEL_ZERO};
      endcase
      return e;
   endfunction

endpackage

### hdl/lcd_seq_ctrl.sv
module lcd_seq_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  lcd_seq_pkg::dp_status_type   status,
   output lcd_seq_pkg::ctl_cmd_type     cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type                        state_ff, state_in;
   logic [lcd_seq_pkg::StepBits-1:0] step_ff, step_in;
   logic [lcd_seq_pkg::StepBits-1:0] last_ff, last_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             out_free;
   logic                             load;
   logic                             at_last;
   logic                             final_load;
   logic                             accept;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign load       = (state_ff == ST_RUN) && out_free;
   assign at_last    = (step_ff == last_ff);
   assign final_load = load && at_last;
   // take a new request while idle or on the cycle that loads the last transfer
   assign req_stall  = !((state_ff == ST_IDLE) || final_load);
   assign accept     = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      last_in  = last_ff;
      priority if (accept) begin
         step_in = '0;
         unique case (status.kind)
            lcd_seq_pkg::RUN_BYTE: begin
               state_in = ST_RUN;
               last_in  = lcd_seq_pkg::ByteLastStep;
            end
            lcd_seq_pkg::RUN_INIT: begin
               state_in = ST_RUN;
               last_in  = lcd_seq_pkg::InitLastStep;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end else if (final_load) begin
         state_in = ST_IDLE;
      end else if (load) begin
         step_in = step_ff + 1'b1;
      end else begin
         // hold
         state_in = state_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign cmd.capture = accept;
   assign cmd.load    = load;
   assign cmd.step    = step_ff;
   assign cmd.last    = at_last;

endmodule

### hdl/lcd_seq_datapath.sv
module lcd_seq_datapath #(
   parameter int WAIT_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [2:0]                   csr_index,
   input  logic [15:0]                  csr_write_data,
   input  logic [2:0]                   req_cmd,
   input  logic [7:0]                   req_byte_value,
   input  logic [7:0]                   req_column,
   input  logic [2:0]                   req_row,
   input  logic [2:0]                   req_glyph_slot,
   input  lcd_seq_pkg::ctl_cmd_type     cmd,
   output lcd_seq_pkg::dp_status_type   status,
   output logic                         rsp_reg_select,
   output logic [3:0]                   rsp_nibble,
   output logic                         rsp_strobe_res,
   output logic [15:0]                  rsp_wait_after_us,
   output logic                         rsp_last
);

   localparam int WW = lcd_seq_pkg::WaitWidth;
   localparam logic [32:0] WaitMax = (33'd1 << WAIT_BITS) - 33'd1;

   // configuration
   logic [6:0]    row_base_ff [0:3];
   logic [WW-1:0] command_wait_ff;
   logic [WW-1:0] data_wait_ff;
   logic [WW-1:0] long_wait_ff;

   // decoded request
   lcd_seq_pkg::run_kind_type   kind;
   lcd_seq_pkg::wait_class_type wclass;
   logic                        rs;
   logic [7:0]                  cmd_byte;
   logic [7:0]                  cursor_byte;
   logic [6:0]                  row_base;
   logic                        row_ok;

   // captured request
   logic                        init_ff;
   logic                        rs_ff;
   logic [7:0]                  byte_ff;
   lcd_seq_pkg::wait_class_type wclass_ff;

   // transfer being loaded
   lcd_seq_pkg::step_entry_type entry;
   logic [WW:0]                 final_wait;
   logic [WW:0]                 raw_wait;
   logic [WW-1:0]               sat_wait;

   logic                        rsp_reg_select_ff;
   logic [3:0]                  rsp_nibble_ff;
   logic                        rsp_strobe_res_ff;
   logic [WW-1:0]               rsp_wait_after_us_ff;
   logic                        rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_base_ff[0]  <= 7'd0;
         row_base_ff[1]  <= 7'd64;
         row_base_ff[2]  <= 7'd16;
         row_base_ff[3]  <= 7'd80;
         command_wait_ff <= 16'd42;
         data_wait_ff    <= 16'd46;
         long_wait_ff    <= 16'd2000;
      end else if (csr_write_enable) begin
         unique case (lcd_seq_pkg::csr_index_type'(csr_index))
            lcd_seq_pkg::CSR_ROW1_BASE:    row_base_ff[0]  <= csr_write_data[6:0];
            lcd_seq_pkg::CSR_ROW2_BASE:    row_base_ff[1]  <= csr_write_data[6:0];
            lcd_seq_pkg::CSR_ROW3_BASE:    row_base_ff[2]  <= csr_write_data[6:0];
            lcd_seq_pkg::CSR_ROW4_BASE:    row_base_ff[3]  <= csr_write_data[6:0];
            lcd_seq_pkg::CSR_COMMAND_WAIT: command_wait_ff <= csr_write_data;
            lcd_seq_pkg::CSR_DATA_WAIT:    data_wait_ff    <= csr_write_data;
            lcd_seq_pkg::CSR_LONG_WAIT:    long_wait_ff    <= csr_write_data;
            // strobe width belongs to the bus driver; no transfer depends on it
            default: ;
         endcase
      end
   end

   assign row_ok      = (req_row >= 3'd1) && (req_row <= 3'd4);
   assign row_base    = row_base_ff[2'(req_row - 3'd1)];
   assign cursor_byte = lcd_seq_pkg::CursorBase + {1'b0, row_base} + req_column;

   always_comb begin
      kind     = lcd_seq_pkg::RUN_BYTE;
      wclass   = lcd_seq_pkg::WCLS_CMD;
      rs       = 1'b0;
      cmd_byte = req_byte_value;
      unique case (lcd_seq_pkg::cmd_type'(req_cmd))
         lcd_seq_pkg::CMD_INIT: begin
            kind   = lcd_seq_pkg::RUN_INIT;
            wclass = lcd_seq_pkg::WCLS_LONG;
         end
         lcd_seq_pkg::CMD_BYTE: begin
            cmd_byte = req_byte_value;
         end
         lcd_seq_pkg::CMD_DATA: begin
            rs     = 1'b1;
            wclass = lcd_seq_pkg::WCLS_DATA;
         end
         lcd_seq_pkg::CMD_CURSOR: begin
            cmd_byte = cursor_byte;
            if (!row_ok) begin
               kind = lcd_seq_pkg::RUN_NONE;
            end
         end
         lcd_seq_pkg::CMD_CLEAR: begin
            cmd_byte = lcd_seq_pkg::ClearByte;
            wclass   = lcd_seq_pkg::WCLS_LONG;
         end
         lcd_seq_pkg::CMD_HOME: begin
            cmd_byte = lcd_seq_pkg::HomeByte;
            wclass   = lcd_seq_pkg::WCLS_LONG;
         end
         lcd_seq_pkg::CMD_GLYPH: begin
            cmd_byte = lcd_seq_pkg::GlyphBase | {2'b00, req_glyph_slot, 3'b000};
         end
         default: begin
            kind = lcd_seq_pkg::RUN_NONE;
         end
      endcase
   end

   assign status.kind = kind;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         init_ff   <= (kind == lcd_seq_pkg::RUN_INIT);
         rs_ff     <= rs;
         byte_ff   <= cmd_byte;
         wclass_ff <= wclass;
      end
   end

   always_comb begin
      if (init_ff) begin
         entry = lcd_seq_pkg::init_entry(cmd.step);
      end else if (cmd.step == '0) begin
         entry = '{nibble: byte_ff[7:4], strobe: 1'b1, wsel: lcd_seq_pkg::WSEL_ZERO};
      end else begin
         entry = '{nibble: byte_ff[3:0], strobe: 1'b1, wsel: lcd_seq_pkg::WSEL_FINAL};
      end
   end

   always_comb begin
      unique case (wclass_ff)
         lcd_seq_pkg::WCLS_DATA: final_wait = {1'b0, data_wait_ff};
         lcd_seq_pkg::WCLS_LONG: final_wait = {1'b0, command_wait_ff} + {1'b0, long_wait_ff};
         default:                final_wait = {1'b0, command_wait_ff};
      endcase
   end

   always_comb begin
      unique case (entry.wsel)
         lcd_seq_pkg::WSEL_BOOT:   raw_wait = lcd_seq_pkg::BootWait;
         lcd_seq_pkg::WSEL_RESET1: raw_wait = lcd_seq_pkg::Reset1Wait;
         lcd_seq_pkg::WSEL_RESET2: raw_wait = lcd_seq_pkg::Reset2Wait;
         lcd_seq_pkg::WSEL_CMD:    raw_wait = {1'b0, command_wait_ff};
         lcd_seq_pkg::WSEL_FINAL:  raw_wait = final_wait;
         default:                  raw_wait = '0;
      endcase
   end

   // clamp to the largest wait the bus driver can count
   assign sat_wait = ({16'd0, raw_wait} > WaitMax) ? WaitMax[WW-1:0] : raw_wait[WW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_reg_select_ff    <= rs_ff && !init_ff;
         rsp_nibble_ff        <= entry.nibble;
         rsp_strobe_res_ff    <= entry.strobe;
         rsp_wait_after_us_ff <= sat_wait;
         rsp_last_ff          <= cmd.last;
      end
   end

   assign rsp_reg_select    = rsp_reg_select_ff;
   assign rsp_nibble        = rsp_nibble_ff;
   assign rsp_strobe_res    = rsp_strobe_res_ff;
   assign rsp_wait_after_us = rsp_wait_after_us_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

### hdl/char_lcd_nibble_sequencer.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  cmd, byte_value, column, row, glyph_slot
// rsp_      out        rsp_valid/rsp_stall  reg_select, nibble, strobe_res, wait_after_us, last
// csr_      in         csr_write_enable     csr_index, csr_write_data
//
// One bus transfer leaves per cycle while the output is not stalled, from a single output
// register, so a byte request is sent as 2 transfers and init as 13; some requests send none.
// A new request is taken on the cycle that loads the last transfer of the current run.
// Reset is synchronous and restores the register defaults and an empty output.
// A stalled output register holds its transfer and the sequence pauses behind it.
module char_lcd_nibble_sequencer #(
   parameter int WAIT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_write_data,
   // requests
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [7:0]  req_byte_value,
   input  logic [7:0]  req_column,
   input  logic [2:0]  req_row,
   input  logic [2:0]  req_glyph_slot,
   // bus transfers
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_reg_select,
   output logic [3:0]  rsp_nibble,
   output logic        rsp_strobe_res,
   output logic [15:0] rsp_wait_after_us,
   output logic        rsp_last
);

   // Command and status between sequencer and datapath
   lcd_seq_pkg::ctl_cmd_type   ctl_cmd;
   lcd_seq_pkg::dp_status_type dp_status;

   // Sequencer: step counter, run length, output valid
   lcd_seq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (dp_status),
      .cmd       (ctl_cmd)
   );

   // Datapath: registers, request decode and capture, transfer assembly
   lcd_seq_datapath #(
      .WAIT_BITS (WAIT_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_cmd           (req_cmd),
      .req_byte_value    (req_byte_value),
      .req_column        (req_column),
      .req_row           (req_row),
      .req_glyph_slot    (req_glyph_slot),
      .cmd               (ctl_cmd),
      .status            (dp_status),
      .rsp_reg_select    (rsp_reg_select),
      .rsp_nibble        (rsp_nibble),
      .rsp_strobe_res    (rsp_strobe_res),
      .rsp_wait_after_us (rsp_wait_after_us),
      .rsp_last          (rsp_last)
   );

   // Inside a run the next transfer is loaded on the same edge the current one leaves
   a_run_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=> rsp_valid)
      else $error("gap inside a transfer run");

   // A wait-only transfer only occurs as the boot wait: command register, nibble zero
   a_wait_only_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_strobe_res) |-> (!rsp_reg_select && rsp_nibble == 4'h0))
      else $error("wait-only transfer with payload");

   // The step counter never runs past the power-on sequence
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.load |-> (ctl_cmd.step <= 4'(lcd_seq_pkg::InitSteps - 1)))
      else $error("step counter out of range");

endmodule
